/* rtl/core/top_n_longest_duration_tracker_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the top-N duration tracker
// Shared property shapes, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TOP_N_LONGEST_DURATION_TRACKER_CORE_MACROS_SVH
`define TOP_N_LONGEST_DURATION_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define NTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ntl_pkg.sv */
// ---------------------------------------------------------------------------
// ntl_pkg
// Constants, codes and shared types of the top-N duration tracker.
// ---------------------------------------------------------------------------
package ntl_pkg;

   localparam int TOP_N         = 16;
   localparam int TIME_BITS     = 48;
   localparam int TAG_BITS      = 16;
   localparam int RANK_BITS     = 4;
   localparam int CNT_BITS      = 5;
   localparam int STMT_BITS     = 32;
   localparam int SUM_BITS      = 64;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;

   localparam logic [CNT_BITS-1:0] RESET_RANKS = CNT_BITS'(10);

   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_REPLY  = 2'd1,
      OP_REPORT = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLED      = CSR_IDX_BITS'(0),
      CSR_ACTIVE_COUNT = CSR_IDX_BITS'(1)
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] duration;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // control from the sequencer to the cell row
   typedef struct packed {
      logic                 en;
      logic [TIME_BITS-1:0] duration;
      logic [TAG_BITS-1:0]  tag;
      logic [CNT_BITS-1:0]  ranks;
      logic [RANK_BITS-1:0] rd_idx;
   } ins_ctrl_type;

   // status from the cell row back to the sequencer
   typedef struct packed {
      logic      placed;
      entry_type rd_entry;
   } chain_stat_type;

   // clamp the programmed rank count to 1..TOP_N
   function automatic logic [CNT_BITS-1:0] rank_count(input logic [CNT_BITS-1:0] ac);
      logic [CNT_BITS-1:0] n;
      n = ac;
      if (ac == '0) n = CNT_BITS'(1);
      else if (ac > CNT_BITS'(TOP_N)) n = CNT_BITS'(TOP_N);
      return n;
   endfunction

endpackage

/* rtl/core/ntl_req_if.sv */
// ---------------------------------------------------------------------------
// ntl_req_if
// Request channel: opcode, timestamp, tag and selection flag.
// ---------------------------------------------------------------------------
interface ntl_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [ntl_pkg::TIME_BITS-1:0] timestamp;
   logic [ntl_pkg::TAG_BITS-1:0]  request_tag;
   logic                          selected;

   modport source (output valid, output opcode, output timestamp, output request_tag,
                   output selected, input ready);
   modport sink (input valid, input opcode, input timestamp, input request_tag,
                 input selected, output ready);
endinterface

/* rtl/core/ntl_rsp_if.sv */
// ---------------------------------------------------------------------------
// ntl_rsp_if
// Response channel: release notices and report entries.
// ---------------------------------------------------------------------------
interface ntl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [ntl_pkg::RANK_BITS-1:0] rank;
   logic [ntl_pkg::TIME_BITS-1:0] duration;
   logic [ntl_pkg::TAG_BITS-1:0]  tag;
   logic                          tag_valid;
   logic                          last;
   logic [ntl_pkg::STMT_BITS-1:0] statement_count;
   logic [ntl_pkg::SUM_BITS-1:0]  total_time;

   modport source (output valid, output kind, output rank, output duration, output tag,
                   output tag_valid, output last, output statement_count,
                   output total_time, input ready);
   modport sink (input valid, input kind, input rank, input duration, input tag,
                 input tag_valid, input last, input statement_count,
                 input total_time, output ready);
endinterface

/* rtl/core/ntl_csr_if.sv */
// ---------------------------------------------------------------------------
// ntl_csr_if
// Register write channel: index and write data.
// ---------------------------------------------------------------------------
interface ntl_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ntl_pkg::CSR_IDX_BITS-1:0]  index;
   logic [ntl_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ntl_cell.sv */
// ---------------------------------------------------------------------------
// ntl_cell
// One rank of the sorted table: compares, takes the new entry or the one
// handed down by its upper neighbor.
// ---------------------------------------------------------------------------
module ntl_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                active,
   input  ntl_pkg::entry_type  new_entry,
   input  ntl_pkg::entry_type  up_entry,
   input  logic                hit_in,
   output logic                hit_out,
   output logic                load_new,
   output ntl_pkg::entry_type  entry
);

   ntl_pkg::entry_type entry_ff;
   ntl_pkg::entry_type entry_in;
   logic               take;
   logic               shift;

   // empty slot or strictly shorter entry: new request belongs here or above
   assign take     = active & (~entry_ff.valid | (entry_ff.duration < new_entry.duration));
   assign hit_out  = hit_in | take;
   assign load_new = en & take & ~hit_in;
   assign shift    = en & active & hit_in;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = up_entry;
      end else if (load_new) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

/* rtl/core/ntl_chain.sv */
// ---------------------------------------------------------------------------
// ntl_chain
// Row of rank cells; each cell hands its entry to the next one down.
// ---------------------------------------------------------------------------
`include "top_n_longest_duration_tracker_core_macros.svh"

module ntl_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  ntl_pkg::ins_ctrl_type   ctrl,
   output ntl_pkg::chain_stat_type stat
);

   ntl_pkg::entry_type             cell_q [ntl_pkg::TOP_N];
   ntl_pkg::entry_type             new_entry;
   logic [ntl_pkg::TOP_N:0]        hit_chain;
   logic [ntl_pkg::TOP_N-1:0]      load_new;
   logic [ntl_pkg::TOP_N-1:0]      valid_vec;

   assign new_entry.valid    = 1'b1;
   assign new_entry.duration = ctrl.duration;
   assign new_entry.tag      = ctrl.tag;
   assign hit_chain[0]       = 1'b0;

   for (genvar i = 0; i < ntl_pkg::TOP_N; i++) begin : g_cell
      ntl_pkg::entry_type up_entry;
      logic               active;

      if (i == 0) begin : g_head
         assign up_entry = '0;
      end else begin : g_body
         assign up_entry = cell_q[i-1];
      end

      assign active       = (ntl_pkg::CNT_BITS'(i) < ctrl.ranks);
      assign valid_vec[i] = cell_q[i].valid;

      ntl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (ctrl.en),
         .active    (active),
         .new_entry (new_entry),
         .up_entry  (up_entry),
         .hit_in    (hit_chain[i]),
         .hit_out   (hit_chain[i+1]),
         .load_new  (load_new[i]),
         .entry     (cell_q[i])
      );
   end

   assign stat.placed   = hit_chain[ntl_pkg::TOP_N];
   assign stat.rd_entry = cell_q[ctrl.rd_idx];

   `NTL_ASSERT_NOW(a_single_insert, 1'b1, $onehot0(load_new), "new entry written to more than one rank")
   `NTL_ASSERT_NEXT(a_hold_when_idle, !ctrl.en, $stable(valid_vec), "table changed without an insert")
   `NTL_ASSERT_NEXT(a_insert_fills, ctrl.en && stat.placed, valid_vec != '0, "insert left table empty")

endmodule

/* rtl/core/top_n_longest_duration_tracker_core.sv */
// ---------------------------------------------------------------------------
// top_n_longest_duration_tracker_core
// Start and reply requests are accepted, then executed; a reply waits in
// execute until the output register is free, and its release notice is
// registered as it leaves execute. A report streams one rank per cycle,
// while the response channel is ready, through the single read port of the
// cell row; replies insert into that row. Synchronous reset clears the
// table, pending request and totals; enabled comes up 1 and the rank count 10.
// ---------------------------------------------------------------------------
`include "top_n_longest_duration_tracker_core_macros.svh"

module top_n_longest_duration_tracker_core (
   input  logic        clock,
   input  logic        reset,
   ntl_req_if.sink     req_ch,
   ntl_rsp_if.source   rsp_ch,
   ntl_csr_if.sink     csr_ch
);

   typedef struct packed {
      logic                          kind;
      logic [ntl_pkg::RANK_BITS-1:0] rank;
      logic [ntl_pkg::TIME_BITS-1:0] duration;
      logic [ntl_pkg::TAG_BITS-1:0]  tag;
      logic                          tag_valid;
      logic                          last;
      logic [ntl_pkg::STMT_BITS-1:0] statement_count;
      logic [ntl_pkg::SUM_BITS-1:0]  total_time;
   } rsp_payload_type;

   ntl_pkg::state_type               state_ff, state_in;
   logic                             enabled_ff;
   logic [ntl_pkg::CNT_BITS-1:0]     active_count_ff;
   ntl_pkg::opcode_type              op_ff, op_in;
   logic                             sel_ff, sel_in;
   logic [ntl_pkg::TAG_BITS-1:0]     tag_ff, tag_in;
   logic [ntl_pkg::TIME_BITS-1:0]    ts_ff, ts_in;
   logic [ntl_pkg::TIME_BITS-1:0]    dur_ff, dur_in;
   logic [ntl_pkg::TIME_BITS-1:0]    start_time_ff, start_time_in;
   logic                             pending_valid_ff, pending_valid_in;
   logic [ntl_pkg::TAG_BITS-1:0]     pending_tag_ff, pending_tag_in;
   logic [ntl_pkg::STMT_BITS-1:0]    stmt_ff, stmt_in;
   logic [ntl_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic [ntl_pkg::CNT_BITS-1:0]     rank_cnt_ff, rank_cnt_in;
   logic                             out_valid_ff, out_valid_in;
   rsp_payload_type                  out_ff, out_in;

   logic                             req_accept;
   logic                             out_free;
   logic                             ins_en;
   logic [ntl_pkg::CNT_BITS-1:0]     ranks;
   logic [ntl_pkg::CNT_BITS-1:0]     ranks_m1;
   logic [ntl_pkg::SUM_BITS:0]       sum_wide;
   logic [ntl_pkg::SUM_BITS-1:0]     sum_sat;
   ntl_pkg::ins_ctrl_type            ins;
   ntl_pkg::chain_stat_type          stat;

   assign req_ch.ready = (state_ff == ntl_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid & req_ch.ready;
   assign out_free     = ~out_valid_ff | rsp_ch.ready;
   assign ranks        = ntl_pkg::rank_count(active_count_ff);
   assign ranks_m1     = ranks - ntl_pkg::CNT_BITS'(1);
   assign sum_wide     = {1'b0, sum_ff} + (ntl_pkg::SUM_BITS+1)'(dur_ff);
   assign sum_sat      = sum_wide[ntl_pkg::SUM_BITS] ? '1 : sum_wide[ntl_pkg::SUM_BITS-1:0];

   assign ins.en       = ins_en;
   assign ins.duration = dur_ff;
   assign ins.tag      = pending_tag_ff;
   assign ins.ranks    = ranks;
   // report walks the ranks; a reply looks at the last rank for eviction
   assign ins.rd_idx   = (state_ff == ntl_pkg::ST_REPORT) ?
                         rank_cnt_ff[ntl_pkg::RANK_BITS-1:0] :
                         ranks_m1[ntl_pkg::RANK_BITS-1:0];

   ntl_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ins),
      .stat  (stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ntl_pkg::ST_IDLE: begin
            if (req_accept) state_in = ntl_pkg::ST_EXEC;
         end
         ntl_pkg::ST_EXEC: begin
            case (op_ff)
               ntl_pkg::OP_REPLY: begin
                  if (out_free) state_in = ntl_pkg::ST_IDLE;
               end
               ntl_pkg::OP_REPORT: state_in = ntl_pkg::ST_REPORT;
               default: state_in = ntl_pkg::ST_IDLE;
            endcase
         end
         ntl_pkg::ST_REPORT: begin
            if (out_free && rank_cnt_ff == ranks_m1) state_in = ntl_pkg::ST_IDLE;
         end
         default: state_in = ntl_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in            = op_ff;
      sel_in           = sel_ff;
      tag_in           = tag_ff;
      ts_in            = ts_ff;
      dur_in           = dur_ff;
      start_time_in    = start_time_ff;
      pending_valid_in = pending_valid_ff;
      pending_tag_in   = pending_tag_ff;
      stmt_in          = stmt_ff;
      sum_in           = sum_ff;
      rank_cnt_in      = rank_cnt_ff;
      out_valid_in     = out_valid_ff;
      out_in           = out_ff;
      ins_en           = 1'b0;

      if (rsp_ch.valid && rsp_ch.ready) out_valid_in = 1'b0;

      unique case (state_ff)
         ntl_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in  = ntl_pkg::opcode_type'(req_ch.opcode);
               sel_in = req_ch.selected;
               tag_in = req_ch.request_tag;
               ts_in  = req_ch.timestamp;
               // wraps when time runs backwards
               dur_in = req_ch.timestamp - start_time_ff;
            end
         end
         ntl_pkg::ST_EXEC: begin
            case (op_ff)
               ntl_pkg::OP_START: begin
                  if (enabled_ff && sel_ff) begin
                     if (stmt_ff != '1) stmt_in = stmt_ff + ntl_pkg::STMT_BITS'(1);
                     pending_valid_in = 1'b1;
                     pending_tag_in   = tag_ff;
                     start_time_in    = ts_ff;
                  end
               end
               ntl_pkg::OP_REPLY: begin
                  if (out_free) begin
                     out_valid_in           = 1'b1;
                     out_in.kind            = ntl_pkg::KIND_RELEASE;
                     out_in.rank            = '0;
                     out_in.last            = 1'b1;
                     out_in.statement_count = stmt_ff;
                     out_in.duration        = '0;
                     out_in.tag             = '0;
                     out_in.tag_valid       = 1'b0;
                     if (pending_valid_ff) begin
                        ins_en           = 1'b1;
                        sum_in           = sum_sat;
                        pending_valid_in = 1'b0;
                        pending_tag_in   = '0;
                        if (!stat.placed) begin
                           // rejected: release the new request itself
                           out_in.duration  = dur_ff;
                           out_in.tag       = pending_tag_ff;
                           out_in.tag_valid = 1'b1;
                        end else if (stat.rd_entry.valid) begin
                           // evict the shortest ranked entry
                           out_in.duration  = stat.rd_entry.duration;
                           out_in.tag       = stat.rd_entry.tag;
                           out_in.tag_valid = 1'b1;
                        end else begin
                           out_in.duration  = dur_ff;
                        end
                     end
                     out_in.total_time = sum_in;
                  end
               end
               ntl_pkg::OP_REPORT: rank_cnt_in = '0;
               default: ;
            endcase
         end
         ntl_pkg::ST_REPORT: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_in.kind            = ntl_pkg::KIND_REPORT;
               out_in.rank            = rank_cnt_ff[ntl_pkg::RANK_BITS-1:0];
               out_in.duration        = stat.rd_entry.valid ? stat.rd_entry.duration : '0;
               out_in.tag             = stat.rd_entry.valid ? stat.rd_entry.tag : '0;
               out_in.tag_valid       = stat.rd_entry.valid;
               out_in.last            = (rank_cnt_ff == ranks_m1);
               out_in.statement_count = stmt_ff;
               out_in.total_time      = sum_ff;
               rank_cnt_in            = rank_cnt_ff + ntl_pkg::CNT_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ntl_pkg::ST_IDLE;
         enabled_ff       <= 1'b1;
         active_count_ff  <= ntl_pkg::RESET_RANKS;
         pending_valid_ff <= 1'b0;
         pending_tag_ff   <= '0;
         start_time_ff    <= '0;
         stmt_ff          <= '0;
         sum_ff           <= '0;
         rank_cnt_ff      <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pending_valid_ff <= pending_valid_in;
         pending_tag_ff   <= pending_tag_in;
         start_time_ff    <= start_time_in;
         stmt_ff          <= stmt_in;
         sum_ff           <= sum_in;
         rank_cnt_ff      <= rank_cnt_in;
         out_valid_ff     <= out_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (ntl_pkg::csr_index_type'(csr_ch.index))
               ntl_pkg::CSR_ENABLED:      enabled_ff      <= csr_ch.data[0];
               ntl_pkg::CSR_ACTIVE_COUNT: active_count_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      sel_ff <= sel_in;
      tag_ff <= tag_in;
      ts_ff  <= ts_in;
      dur_ff <= dur_in;
      out_ff <= out_in;
   end

   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.kind            = out_ff.kind;
   assign rsp_ch.rank            = out_ff.rank;
   assign rsp_ch.duration        = out_ff.duration;
   assign rsp_ch.tag             = out_ff.tag;
   assign rsp_ch.tag_valid       = out_ff.tag_valid;
   assign rsp_ch.last            = out_ff.last;
   assign rsp_ch.statement_count = out_ff.statement_count;
   assign rsp_ch.total_time      = out_ff.total_time;

   `NTL_ASSERT_NEXT(a_stmt_monotone, 1'b1, stmt_ff >= $past(stmt_ff), "statement count decreased")
   `NTL_ASSERT_NEXT(a_sum_monotone, 1'b1, sum_ff >= $past(sum_ff), "total time decreased")
   `NTL_ASSERT_NOW(a_report_last_rank, rsp_ch.valid && rsp_ch.kind == ntl_pkg::KIND_REPORT && rsp_ch.last, rsp_ch.rank == ranks_m1[ntl_pkg::RANK_BITS-1:0], "report ended at wrong rank")
   `NTL_ASSERT_NEXT(a_reply_clears_pending, ins.en, !pending_valid_ff, "pending request survived its reply")

endmodule
